// ===== design/rmq_pkg.sv =====
package rmq_pkg;

   localparam int FRAC_BITS = 14;
   localparam int ELEM_W    = 16;
   localparam int ONE       = 1 << FRAC_BITS;
   localparam int ROOT_W    = 15;             // floor(sqrt(radicand << 12)) < 2^15
   localparam int SQREM_W   = 31;
   localparam int MAG_W     = 17;             // |a +/- b| of two elements
   localparam int QUO_W     = 16;
   localparam int DVREM_W   = 34;
   localparam int BIDX_W    = 4;

   typedef enum logic [1:0] {
      BR_TRACE = 2'd0,
      BR_X     = 2'd1,
      BR_Y     = 2'd2,
      BR_Z     = 2'd3
   } branch_type;

   typedef struct packed {
      logic       vld;
      branch_type br;
      logic [2:0] neg;
   } rmq_ctl_type;

   typedef logic [2:0][MAG_W-1:0]   rmq_mag_type;
   typedef logic [2:0][DVREM_W-1:0] rmq_drem_type;
   typedef logic [2:0][QUO_W-1:0]   rmq_quo_type;

endpackage

// ===== design/rmq_sqrt_cell.sv =====
module rmq_sqrt_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic [rmq_pkg::BIDX_W-1:0]         bit_idx,
   input  rmq_pkg::rmq_ctl_type               ctl_i,
   input  rmq_pkg::rmq_mag_type               mag_i,
   input  logic [rmq_pkg::SQREM_W-1:0]        rem_i,
   input  logic [rmq_pkg::ROOT_W-1:0]         root_i,
   output rmq_pkg::rmq_ctl_type               ctl_o,
   output rmq_pkg::rmq_mag_type               mag_o,
   output logic [rmq_pkg::SQREM_W-1:0]        rem_o,
   output logic [rmq_pkg::ROOT_W-1:0]         root_o
);
   import rmq_pkg::*;

   rmq_ctl_type          ctl_ff;
   rmq_mag_type          mag_ff;
   logic [SQREM_W-1:0]   rem_ff, rem_in, trial;
   logic [ROOT_W-1:0]    root_ff, root_in;

   // try setting this root bit: (q + 2^b)^2 - q^2 = q*2^(b+1) + 2^(2b)
   always_comb begin
      trial = (SQREM_W'(root_i) << (bit_idx + 1'b1)) | (SQREM_W'(1) << {bit_idx, 1'b0});
      if (rem_i >= trial) begin
         rem_in  = rem_i - trial;
         root_in = root_i | (ROOT_W'(1) << bit_idx);
      end else begin
         rem_in  = rem_i;
         root_in = root_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.vld <= 1'b0;
      end else if (en) begin
         ctl_ff.vld <= ctl_i.vld;
      end
      if (en) begin
         ctl_ff.br  <= ctl_i.br;
         ctl_ff.neg <= ctl_i.neg;
         mag_ff     <= mag_i;
         rem_ff     <= rem_in;
         root_ff    <= root_in;
      end
   end

   assign ctl_o  = ctl_ff;
   assign mag_o  = mag_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

// ===== design/rmq_div_cell.sv =====
module rmq_div_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic [rmq_pkg::BIDX_W-1:0]         bit_idx,
   input  rmq_pkg::rmq_ctl_type               ctl_i,
   input  logic [rmq_pkg::ROOT_W-1:0]         pivot_i,
   input  logic [2:0]                         ovf_i,
   input  rmq_pkg::rmq_drem_type              rem_i,
   input  rmq_pkg::rmq_quo_type               quo_i,
   output rmq_pkg::rmq_ctl_type               ctl_o,
   output logic [rmq_pkg::ROOT_W-1:0]         pivot_o,
   output logic [2:0]                         ovf_o,
   output rmq_pkg::rmq_drem_type              rem_o,
   output rmq_pkg::rmq_quo_type               quo_o
);
   import rmq_pkg::*;

   rmq_ctl_type         ctl_ff;
   logic [ROOT_W-1:0]   pivot_ff;
   logic [2:0]          ovf_ff;
   rmq_drem_type        rem_ff, rem_in;
   rmq_quo_type         quo_ff, quo_in;
   logic [DVREM_W-1:0]  dsh;

   // divisor is 4 * pivot, shifted to this quotient bit
   always_comb begin
      dsh = DVREM_W'({pivot_i, 2'b00}) << bit_idx;
      for (int l = 0; l < 3; l++) begin
         if (rem_i[l] >= dsh) begin
            rem_in[l] = rem_i[l] - dsh;
            quo_in[l] = quo_i[l] | (QUO_W'(1) << bit_idx);
         end else begin
            rem_in[l] = rem_i[l];
            quo_in[l] = quo_i[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.vld <= 1'b0;
      end else if (en) begin
         ctl_ff.vld <= ctl_i.vld;
      end
      if (en) begin
         ctl_ff.br  <= ctl_i.br;
         ctl_ff.neg <= ctl_i.neg;
         pivot_ff   <= pivot_i;
         ovf_ff     <= ovf_i;
         rem_ff     <= rem_in;
         quo_ff     <= quo_in;
      end
   end

   assign ctl_o   = ctl_ff;
   assign pivot_o = pivot_ff;
   assign ovf_o   = ovf_ff;
   assign rem_o   = rem_ff;
   assign quo_o   = quo_ff;

endmodule

// ===== design/rotation_matrix_to_quaternion_core.sv =====
// Pipeline: a request passes 1 setup stage, 15 square root cells, 16 divider
//   cells and 1 output register on its way to rsp_valid.
// Throughput: one matrix per cycle while rsp_ready does not stall the output;
//   every cell row advances together, one root bit or one quotient bit per cell.
// Reset: synchronous, active high; clears all valid bits, payload is not reset.
module rotation_matrix_to_quaternion_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [15:0]           req_elem_r0c0,
   input  logic signed [15:0]           req_elem_r0c1,
   input  logic signed [15:0]           req_elem_r0c2,
   input  logic signed [15:0]           req_elem_r1c0,
   input  logic signed [15:0]           req_elem_r1c1,
   input  logic signed [15:0]           req_elem_r1c2,
   input  logic signed [15:0]           req_elem_r2c0,
   input  logic signed [15:0]           req_elem_r2c1,
   input  logic signed [15:0]           req_elem_r2c2,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [15:0]           rsp_quat_x,
   output logic signed [15:0]           rsp_quat_y,
   output logic signed [15:0]           rsp_quat_z,
   output logic signed [15:0]           rsp_quat_w,
   output logic [1:0]                   rsp_branch_taken
);
   import rmq_pkg::*;

   localparam int NSQ = ROOT_W;
   localparam int NDV = QUO_W;

   // whole chain moves when the output slot is free or being drained
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // ---------------- setup stage: trace, branch, radicand, numerators
   logic signed [17:0]   trace;
   logic signed [18:0]   rad;
   logic signed [16:0]   num [3];
   branch_type           br_in;
   rmq_ctl_type          s0_ctl_in;
   rmq_mag_type          s0_mag_in;
   logic [SQREM_W-1:0]   s0_rem_in;

   always_comb begin
      trace = 18'(req_elem_r0c0) + 18'(req_elem_r1c1) + 18'(req_elem_r2c2);
      if (trace > 0) begin
         br_in  = BR_TRACE;
         rad    = 19'(trace) + 19'(ONE);
         num[0] = 17'(req_elem_r2c1) - 17'(req_elem_r1c2);
         num[1] = 17'(req_elem_r0c2) - 17'(req_elem_r2c0);
         num[2] = 17'(req_elem_r1c0) - 17'(req_elem_r0c1);
      end else if (req_elem_r0c0 > req_elem_r1c1 && req_elem_r0c0 > req_elem_r2c2) begin
         br_in  = BR_X;
         rad    = 19'(ONE) + (19'(req_elem_r0c0) <<< 1) - 19'(trace);
         num[0] = 17'(req_elem_r0c1) + 17'(req_elem_r1c0);
         num[1] = 17'(req_elem_r0c2) + 17'(req_elem_r2c0);
         num[2] = 17'(req_elem_r2c1) - 17'(req_elem_r1c2);
      end else if (req_elem_r1c1 > req_elem_r2c2) begin
         br_in  = BR_Y;
         rad    = 19'(ONE) + (19'(req_elem_r1c1) <<< 1) - 19'(trace);
         num[0] = 17'(req_elem_r0c1) + 17'(req_elem_r1c0);
         num[1] = 17'(req_elem_r1c2) + 17'(req_elem_r2c1);
         num[2] = 17'(req_elem_r0c2) - 17'(req_elem_r2c0);
      end else begin
         br_in  = BR_Z;
         rad    = 19'(ONE) + (19'(req_elem_r2c2) <<< 1) - 19'(trace);
         num[0] = 17'(req_elem_r0c2) + 17'(req_elem_r2c0);
         num[1] = 17'(req_elem_r1c2) + 17'(req_elem_r2c1);
         num[2] = 17'(req_elem_r1c0) - 17'(req_elem_r0c1);
      end
      // clamp a negative radicand to zero; scale by 2^FRAC_BITS / 4
      if (rad <= 0) begin
         s0_rem_in = '0;
      end else begin
         s0_rem_in = SQREM_W'(rad[17:0]) << (FRAC_BITS - 2);
      end
      s0_ctl_in.vld = req_valid;
      s0_ctl_in.br  = br_in;
      for (int l = 0; l < 3; l++) begin
         s0_ctl_in.neg[l] = num[l][16];
         s0_mag_in[l]     = num[l][16] ? MAG_W'(-num[l]) : MAG_W'(num[l]);
      end
   end

   rmq_ctl_type          sq_ctl  [NSQ+1];
   rmq_mag_type          sq_mag  [NSQ+1];
   logic [SQREM_W-1:0]   sq_rem  [NSQ+1];
   logic [ROOT_W-1:0]    sq_root [NSQ+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ctl[0].vld <= 1'b0;
      end else if (en) begin
         sq_ctl[0].vld <= s0_ctl_in.vld;
      end
      if (en) begin
         sq_ctl[0].br  <= s0_ctl_in.br;
         sq_ctl[0].neg <= s0_ctl_in.neg;
         sq_mag[0]     <= s0_mag_in;
         sq_rem[0]     <= s0_rem_in;
      end
   end
   assign sq_root[0] = '0;

   // ---------------- square root row: one root bit per cell, MSB first
   for (genvar k = 0; k < NSQ; k++) begin : g_sq
      rmq_sqrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .bit_idx (BIDX_W'(NSQ - 1 - k)),
         .ctl_i   (sq_ctl[k]),
         .mag_i   (sq_mag[k]),
         .rem_i   (sq_rem[k]),
         .root_i  (sq_root[k]),
         .ctl_o   (sq_ctl[k+1]),
         .mag_o   (sq_mag[k+1]),
         .rem_o   (sq_rem[k+1]),
         .root_o  (sq_root[k+1])
      );
   end

   // ---------------- divider row: three lanes, one quotient bit per cell
   rmq_ctl_type          dv_ctl   [NDV+1];
   logic [ROOT_W-1:0]    dv_pivot [NDV+1];
   logic [2:0]           dv_ovf   [NDV+1];
   rmq_drem_type         dv_rem   [NDV+1];
   rmq_quo_type          dv_quo   [NDV+1];

   // quotient of 2^16 or more (mag >= 16 * pivot) saturates anyway
   always_comb begin
      dv_ctl[0]   = sq_ctl[NSQ];
      dv_pivot[0] = sq_root[NSQ];
      for (int l = 0; l < 3; l++) begin
         dv_ovf[0][l] = {2'b00, sq_mag[NSQ][l]} >= {sq_root[NSQ], 4'b0000};
         dv_rem[0][l] = DVREM_W'(sq_mag[NSQ][l]) << FRAC_BITS;
         dv_quo[0][l] = '0;
      end
   end

   for (genvar k = 0; k < NDV; k++) begin : g_dv
      rmq_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .bit_idx (BIDX_W'(NDV - 1 - k)),
         .ctl_i   (dv_ctl[k]),
         .pivot_i (dv_pivot[k]),
         .ovf_i   (dv_ovf[k]),
         .rem_i   (dv_rem[k]),
         .quo_i   (dv_quo[k]),
         .ctl_o   (dv_ctl[k+1]),
         .pivot_o (dv_pivot[k+1]),
         .ovf_o   (dv_ovf[k+1]),
         .rem_o   (dv_rem[k+1]),
         .quo_o   (dv_quo[k+1])
      );
   end

   // ---------------- saturate, sign, and place by branch
   rmq_ctl_type          fin;
   logic [ROOT_W-1:0]    piv;
   logic signed [15:0]   pv_sat;
   logic signed [15:0]   lane [3];
   logic [QUO_W-1:0]     qmag;
   logic signed [15:0]   qx_in, qy_in, qz_in, qw_in;
   logic signed [15:0]   qx_ff, qy_ff, qz_ff, qw_ff;
   logic [1:0]           br_ff;
   logic                 vld_ff;

   always_comb begin
      fin    = dv_ctl[NDV];
      piv    = dv_pivot[NDV];
      pv_sat = (piv > ROOT_W'(ONE)) ? 16'(ONE) : 16'(piv);
      for (int l = 0; l < 3; l++) begin
         qmag = (dv_ovf[NDV][l] || dv_quo[NDV][l] > QUO_W'(ONE)) ? QUO_W'(ONE)
                                                                : dv_quo[NDV][l];
         if (piv == '0) begin
            lane[l] = '0;
         end else if (fin.neg[l]) begin
            lane[l] = -16'(qmag);
         end else begin
            lane[l] = 16'(qmag);
         end
      end
      case (fin.br)
         BR_TRACE: begin
            qx_in = lane[0]; qy_in = lane[1]; qz_in = lane[2]; qw_in = pv_sat;
         end
         BR_X: begin
            qx_in = pv_sat;  qy_in = lane[0]; qz_in = lane[1]; qw_in = lane[2];
         end
         BR_Y: begin
            qx_in = lane[0]; qy_in = pv_sat;  qz_in = lane[1]; qw_in = lane[2];
         end
         default: begin
            qx_in = lane[0]; qy_in = lane[1]; qz_in = pv_sat;  qw_in = lane[2];
         end
      endcase
   end

   // output register: hold while the consumer stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= fin.vld;
      end
      if (en) begin
         qx_ff <= qx_in;
         qy_ff <= qy_in;
         qz_ff <= qz_in;
         qw_ff <= qw_in;
         br_ff <= fin.br;
      end
   end

   assign rsp_valid        = vld_ff;
   assign rsp_quat_x       = qx_ff;
   assign rsp_quat_y       = qy_ff;
   assign rsp_quat_z       = qz_ff;
   assign rsp_quat_w       = qw_ff;
   assign rsp_branch_taken = br_ff;

endmodule

// ===== design/rmq_checker.sv =====
module rmq_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_quat_x,
   input logic signed [15:0] rsp_quat_y,
   input logic signed [15:0] rsp_quat_z,
   input logic signed [15:0] rsp_quat_w,
   input logic [1:0]         rsp_branch_taken
);
   import rmq_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quat_x) && $stable(rsp_quat_w))
      else $error("rsp payload changed while stalled");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_quat_x <= 16'sd16384 && rsp_quat_x >= -16'sd16384
                 && rsp_quat_w <= 16'sd16384 && rsp_quat_w >= -16'sd16384)
      else $error("quaternion component beyond one");

   a_wpiv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_branch_taken == BR_TRACE |-> rsp_quat_w >= 0)
      else $error("trace branch gave negative w");

   a_vpiv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_branch_taken != BR_X || rsp_quat_x >= 0)
                 && (rsp_branch_taken != BR_Y || rsp_quat_y >= 0)
                 && (rsp_branch_taken != BR_Z || rsp_quat_z >= 0))
      else $error("pivot component negative");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_quat_x       (rsp_quat_x),
   .rsp_quat_y       (rsp_quat_y),
   .rsp_quat_z       (rsp_quat_z),
   .rsp_quat_w       (rsp_quat_w),
   .rsp_branch_taken (rsp_branch_taken)
);
